@@ hdl/dfl_pkg.sv @@
// Shared types and constants for the debounced fault latch with lockout.
package dfl_pkg;

  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned COUNT_W   = 10;
  localparam int unsigned TALLY_W   = 4;
  localparam int unsigned TIMER_W   = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  localparam int unsigned TIMER_CAP_DEF = 3500;

  localparam logic [LEVEL_W-1:0] TRIP_LEVEL_RST    = 16'd65535;
  localparam logic [LEVEL_W-1:0] RECOVER_LEVEL_RST = 16'd0;
  localparam logic [COUNT_W-1:0] CONFIRM_LIMIT_RST = 10'd10;
  localparam logic [COUNT_W-1:0] HOLD_COUNT_RST    = 10'd300;
  localparam logic [TALLY_W-1:0] LOCK_FAULTS_RST   = 4'd3;
  localparam logic [TIMER_W-1:0] LOCK_WINDOW_RST   = 12'd3000;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIP_LEVEL    = 3'd0,
    CFG_RECOVER_LEVEL = 3'd1,
    CFG_CONFIRM_LIMIT = 3'd2,
    CFG_HOLD_COUNT    = 3'd3,
    CFG_LOCK_FAULTS   = 3'd4,
    CFG_LOCK_WINDOW   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] trip_level;
    logic [LEVEL_W-1:0] recover_level;
    logic [COUNT_W-1:0] confirm_limit;
    logic [COUNT_W-1:0] hold_count;
    logic [TALLY_W-1:0] lock_faults;
    logic [TIMER_W-1:0] lock_window;
  } cfg_t;

  typedef struct packed {
    logic fault;
    logic locked;
  } status_t;

endpackage

@@ hdl/dfl_in_if.sv @@
// Sample channel: valid/ready handshake carrying one measurement.
interface dfl_in_if;
  logic                        valid;
  logic                        ready;
  logic [dfl_pkg::LEVEL_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ hdl/dfl_out_if.sv @@
// Result channel: valid/ready handshake carrying fault and lock status.
interface dfl_out_if;
  logic valid;
  logic ready;
  logic fault;
  logic locked;

  modport source (output valid, output fault, output locked, input ready);
  modport sink   (input valid, input fault, input locked, output ready);
endinterface

@@ hdl/dfl_core.sv @@
// Fault debounce, recovery drain, window timer and lockout state update.
module dfl_core #(
  parameter int unsigned TIMER_CAP = dfl_pkg::TIMER_CAP_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [dfl_pkg::LEVEL_W-1:0] sample_i,
  input  dfl_pkg::cfg_t               cfg_i,
  output dfl_pkg::status_t            status_o
);

  localparam logic [dfl_pkg::TIMER_W-1:0] CAP = TIMER_CAP[dfl_pkg::TIMER_W-1:0];

  logic [dfl_pkg::COUNT_W-1:0] count_q, count_d;
  logic                        fault_q, fault_d;
  logic                        lock_q, lock_d;
  logic                        win_q, win_d;
  logic [dfl_pkg::TALLY_W-1:0] tally_q, tally_d;
  logic [dfl_pkg::TIMER_W-1:0] timer_q, timer_d;

  always_comb begin
    count_d = count_q;
    fault_d = fault_q;
    lock_d  = lock_q;
    win_d   = win_q;
    tally_d = tally_q;
    timer_d = timer_q;

    // debounce: climb until past the limit, then raise and reload
    if (sample_i >= cfg_i.trip_level) begin
      if (count_d <= cfg_i.confirm_limit && count_d != dfl_pkg::COUNT_MAX) begin
        count_d = count_d + 1'b1;
      end else begin
        if (!fault_d) begin
          fault_d = 1'b1;
          if (tally_d != dfl_pkg::TALLY_MAX) tally_d = tally_d + 1'b1;
          win_d = 1'b1;
        end
        count_d = cfg_i.hold_count;
      end
    end

    // recovery uses the lock as it stood before this tick
    if (sample_i < cfg_i.recover_level && !lock_q) begin
      if (fault_d) begin
        if (count_d != '0) count_d = count_d - 1'b1;
        else               fault_d = 1'b0;
      end else begin
        count_d = '0;
      end
    end

    if (win_d && timer_d < CAP) timer_d = timer_d + 1'b1;

    if (timer_d < cfg_i.lock_window && tally_d >= cfg_i.lock_faults) lock_d = 1'b1;

    // window ran out short of the lock tally: drop tally, window and timer
    if (timer_d >= cfg_i.lock_window && tally_d < cfg_i.lock_faults) begin
      tally_d = '0;
      win_d   = 1'b0;
      timer_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fault_q <= 1'b0;
      lock_q  <= 1'b0;
      win_q   <= 1'b0;
      tally_q <= '0;
      timer_q <= '0;
    end else if (step_i) begin
      count_q <= count_d;
      fault_q <= fault_d;
      lock_q  <= lock_d;
      win_q   <= win_d;
      tally_q <= tally_d;
      timer_q <= timer_d;
    end
  end

  assign status_o = '{fault: fault_d, locked: lock_d};

  a_lock_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q |=> lock_q)
    else $error("lock released without reset");

  a_timer_needs_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (timer_q != '0) |-> win_q)
    else $error("window timer running with no open window");

  a_timer_capped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    timer_q <= CAP)
    else $error("window timer beyond its cap");

  a_hold_without_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable({count_q, fault_q, lock_q, win_q, tally_q, timer_q}))
    else $error("state moved without a sample");

endmodule

@@ hdl/debounced_fault_with_lockout_unit.sv @@
// Top level: sample input register, state update, result register and config.
//
//   channel   dir  handshake     payload
//   in_i      in   valid/ready   sample[15:0]
//   out_o     out  valid/ready   fault, locked
//   wr_*_i    in   wr_en_i       wr_idx_i[2:0], wr_data_i[15:0]
//
// One sample per cycle sustained while the output is not stalled; the input
// register loads at the accepting edge and the result register when the sample
// advances out of the input register, which also sets the result valid.
// The state update between the two registers is combinational.
// A stalled output holds the result register and a full input register; input ready follows output space.
// Reset clears the valid flags and core state and loads the register defaults; no clearing pass.
module debounced_fault_with_lockout_unit #(
  parameter int unsigned TIMER_CAP = dfl_pkg::TIMER_CAP_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dfl_in_if.sink                        in_i,
  dfl_out_if.source                     out_o,
  input  logic                          wr_en_i,
  input  logic [dfl_pkg::CFG_IDX_W-1:0] wr_idx_i,
  input  logic [dfl_pkg::CFG_DAT_W-1:0] wr_data_i
);

  dfl_pkg::cfg_t               cfg_q;
  logic                        s1_valid_q;
  logic [dfl_pkg::LEVEL_W-1:0] s1_sample_q;
  logic                        out_valid_q;
  dfl_pkg::status_t            out_q;
  dfl_pkg::status_t            status;
  logic                        s1_adv;

  // advance the sample into the result register when there is room
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trip_level    <= dfl_pkg::TRIP_LEVEL_RST;
      cfg_q.recover_level <= dfl_pkg::RECOVER_LEVEL_RST;
      cfg_q.confirm_limit <= dfl_pkg::CONFIRM_LIMIT_RST;
      cfg_q.hold_count    <= dfl_pkg::HOLD_COUNT_RST;
      cfg_q.lock_faults   <= dfl_pkg::LOCK_FAULTS_RST;
      cfg_q.lock_window   <= dfl_pkg::LOCK_WINDOW_RST;
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        dfl_pkg::CFG_TRIP_LEVEL:    cfg_q.trip_level    <= wr_data_i;
        dfl_pkg::CFG_RECOVER_LEVEL: cfg_q.recover_level <= wr_data_i;
        dfl_pkg::CFG_CONFIRM_LIMIT: cfg_q.confirm_limit <= wr_data_i[dfl_pkg::COUNT_W-1:0];
        dfl_pkg::CFG_HOLD_COUNT:    cfg_q.hold_count    <= wr_data_i[dfl_pkg::COUNT_W-1:0];
        dfl_pkg::CFG_LOCK_FAULTS:   cfg_q.lock_faults   <= wr_data_i[dfl_pkg::TALLY_W-1:0];
        dfl_pkg::CFG_LOCK_WINDOW:   cfg_q.lock_window   <= wr_data_i[dfl_pkg::TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) s1_valid_q <= in_i.valid;
      if (s1_adv) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) s1_sample_q <= in_i.sample;
    if (s1_adv) out_q <= status;
  end

  dfl_core #(
    .TIMER_CAP(TIMER_CAP)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .sample_i (s1_sample_q),
    .cfg_i    (cfg_q),
    .status_o (status)
  );

  assign out_o.valid  = out_valid_q;
  assign out_o.fault  = out_q.fault;
  assign out_o.locked = out_q.locked;

endmodule
